[design/rgbsob_pkg.sv]
package rgbsob_pkg;

    // Line store depth and the widths that follow from it
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    // Gray conversion weights, scaled by 2^GRAY_SHIFT
    localparam int GRAY_SHIFT = 10;
    localparam int GRAY_SUM_W = 18;
    localparam logic [9:0] WEIGHT_RED   = 10'd307;
    localparam logic [9:0] WEIGHT_GREEN = 10'd604;
    localparam logic [9:0] WEIGHT_BLUE  = 10'd113;

    // Gradient and square root widths
    localparam int GRAD_W   = 10;
    localparam int SQ_W     = 22;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam logic [7:0] MAG_LIMIT = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       frame_last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRAY,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

[design/rgb_sobel_edge_magnitude.sv]
// Sobel edge magnitude of an RGB pixel stream in raster order. Each pixel is
// turned to gray, (307R + 604G + 113B) >> 10, and kept in two 2048-entry line
// stores (synchronous-read memories) that feed a 3x3 window. A result beat
// leaves only for interior pixels, carrying min(255, floor(sqrt(gx^2 + gy^2)))
// for the centre one row and one column behind the pixel just taken;
// frame_last marks the final interior pixel of the frame, and border pixels
// give no beat at all. One pixel is in work at a time: a border pixel passes
// line store read, gray, and gradient and write-back; an interior pixel goes
// on to squaring and the digit-by-digit square root, one result bit a cycle.
// A finished result waits in the output register while the next pixel is taken.
// The user writes image_width and image_height on the configuration port between
// frames, not enforced by the block; values below 3 act as 3, a width above 2048 as 2048.
module rgb_sobel_edge_magnitude
    import rgbsob_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  pixel_t               pixel,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    state_t state_reg, state_next;

    logic [WIDTH_W-1:0]  width_cfg_reg;
    logic [HEIGHT_W-1:0] height_cfg_reg;
    logic [WIDTH_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;

    logic [7:0] upper_mem  [MAX_WIDTH];
    logic [7:0] middle_mem [MAX_WIDTH];
    logic [7:0] upper_rd_reg;
    logic [7:0] middle_rd_reg;

    pixel_t     pix_reg;
    logic [7:0] gray_reg;
    logic [7:0] lt_reg, lm_reg, lb_reg, mt_reg, mm_reg, mb_reg;

    logic [COL_W-1:0]    col_reg;
    logic [HEIGHT_W-1:0] row_reg;

    logic              emit_reg;
    logic              last_reg;
    logic [GRAD_W-1:0] abs_gx_reg, abs_gy_reg;
    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;

    logic    result_valid_reg;
    result_t result_reg;

    logic pixel_take;
    logic out_free;

    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [GRAD_W-1:0] gx_left, gx_right, gy_top, gy_bottom;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W:0]   row_inc;
    logic              emit_now;
    logic              last_now;
    logic [SQ_W-1:0]   sq_sum;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic [7:0]        magnitude;

    assign eff_width  = (width_cfg_reg < WIDTH_W'(3)) ? WIDTH_W'(3) :
                        (width_cfg_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) :
                        width_cfg_reg;
    assign eff_height = (height_cfg_reg < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_cfg_reg;

    assign out_free   = !result_valid_reg || result_ready;
    assign pixel_take = pixel_valid && pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // State machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pixel_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    state_next = ST_GRAY;
                end
            end
            ST_GRAY:
            begin
                state_next = ST_GRAD;
            end
            ST_GRAD:
            begin
                state_next = emit_now ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Line stores: read on the accepted beat, written back in ST_GRAD once gray is registered.
    // The next read always targets another column, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            upper_rd_reg  <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GRAD)
        begin
            upper_mem[col_reg]  <= middle_rd_reg;
            middle_mem[col_reg] <= gray_reg;
        end
    end

    assign gray_sum = GRAY_SUM_W'(pix_reg.red)   * GRAY_SUM_W'(WEIGHT_RED)
                    + GRAY_SUM_W'(pix_reg.green) * GRAY_SUM_W'(WEIGHT_GREEN)
                    + GRAY_SUM_W'(pix_reg.blue)  * GRAY_SUM_W'(WEIGHT_BLUE);

    // Column sums for gx, row sums for gy; right column is the fresh one
    assign gx_left   = GRAD_W'(lt_reg) + {1'b0, lm_reg, 1'b0} + GRAD_W'(lb_reg);
    assign gx_right  = GRAD_W'(upper_rd_reg) + {1'b0, middle_rd_reg, 1'b0}
                     + GRAD_W'(gray_reg);
    assign gy_top    = GRAD_W'(lt_reg) + {1'b0, mt_reg, 1'b0} + GRAD_W'(upper_rd_reg);
    assign gy_bottom = GRAD_W'(lb_reg) + {1'b0, mb_reg, 1'b0} + GRAD_W'(gray_reg);

    assign col_inc  = {1'b0, col_reg} + WIDTH_W'(1);
    assign row_inc  = {1'b0, row_reg} + (HEIGHT_W + 1)'(1);
    assign emit_now = (col_reg >= COL_W'(2)) && ({1'b0, col_reg} < eff_width)
                   && (row_reg >= HEIGHT_W'(2)) && (row_reg < eff_height);
    assign last_now = ({1'b0, col_reg} == eff_width - WIDTH_W'(1))
                   && (row_reg == eff_height - HEIGHT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            lt_reg  <= '0;
            lm_reg  <= '0;
            lb_reg  <= '0;
            mt_reg  <= '0;
            mm_reg  <= '0;
            mb_reg  <= '0;
        end
        else if (state_reg == ST_GRAD)
        begin
            // Shift the window one column left
            lt_reg <= mt_reg;
            lm_reg <= mm_reg;
            lb_reg <= mb_reg;
            mt_reg <= upper_rd_reg;
            mm_reg <= middle_rd_reg;
            mb_reg <= gray_reg;
            if (col_inc >= eff_width)
            begin
                col_reg <= '0;
                row_reg <= (row_inc >= {1'b0, eff_height}) ? '0 : row_inc[HEIGHT_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    assign sq_sum = SQ_W'(abs_gx_reg) * SQ_W'(abs_gx_reg)
                  + SQ_W'(abs_gy_reg) * SQ_W'(abs_gy_reg);

    // One root bit per cycle: bring down two radicand bits, try 4*root + 1
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            pix_reg <= pixel;
        end
        unique case (state_reg)
            ST_GRAY:
            begin
                gray_reg <= gray_sum[GRAY_SUM_W-1:GRAY_SHIFT];
            end
            ST_GRAD:
            begin
                abs_gx_reg <= (gx_left >= gx_right) ? gx_left - gx_right : gx_right - gx_left;
                abs_gy_reg <= (gy_top >= gy_bottom) ? gy_top - gy_bottom : gy_bottom - gy_top;
                emit_reg   <= emit_now;
                last_reg   <= last_now;
            end
            ST_SQUARE:
            begin
                rad_reg  <= sq_sum;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= ROOT_CNT_W'(ROOT_W - 1);
            end
            ST_ROOT:
            begin
                rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
                cnt_reg <= cnt_reg - ROOT_CNT_W'(1);
                if (rem_shift >= trial)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign magnitude = (root_reg > ROOT_W'(MAG_LIMIT)) ? MAG_LIMIT : root_reg[7:0];

    // Output register: hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free && emit_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            result_reg.magnitude  <= magnitude;
            result_reg.frame_last <= last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
